>>> sv/saes_pkg.sv
// Package with the shared types, tables and nibble functions of the S-AES encrypt unit.
`default_nettype none

package saes_pkg;

    // Round constants of the key expansion
    localparam logic [7:0] RCON1 = 8'h80;
    localparam logic [7:0] RCON2 = 8'h30;

    // Low bits of the field polynomial x^4 + x + 1
    localparam logic [3:0] GF_POLY_LOW = 4'h3;

    // Nibble substitution box
    localparam logic [3:0] SBOX [16] = '{
        4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
        4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
    };

    // The three expanded round keys
    typedef struct packed {
        logic [15:0] k0;
        logic [15:0] k1;
        logic [15:0] k2;
    } t_round_keys;

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return {SBOX[b[7:4]], SBOX[b[3:0]]};
    endfunction

    function automatic logic [7:0] rot_byte(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

    function automatic logic [15:0] sub_block(input logic [15:0] s);
        return {sub_byte(s[15:8]), sub_byte(s[7:0])};
    endfunction

    // Swap nibble 1 and nibble 3 (bottom row of the state)
    function automatic logic [15:0] shift_block(input logic [15:0] s);
        return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    function automatic logic [3:0] gf_times2(input logic [3:0] a);
        return {a[2:0], 1'b0} ^ (a[3] ? GF_POLY_LOW : 4'h0);
    endfunction

    function automatic logic [3:0] gf_times4(input logic [3:0] a);
        return gf_times2(gf_times2(a));
    endfunction

    // Multiply each column by [1 4; 4 1] over GF(2^4)
    function automatic logic [15:0] mix_block(input logic [15:0] s);
        logic [3:0] m0;
        logic [3:0] m1;
        logic [3:0] m2;
        logic [3:0] m3;
        m0 = s[15:12] ^ gf_times4(s[11:8]);
        m1 = gf_times4(s[15:12]) ^ s[11:8];
        m2 = s[7:4] ^ gf_times4(s[3:0]);
        m3 = gf_times4(s[7:4]) ^ s[3:0];
        return {m0, m1, m2, m3};
    endfunction

    // Expand the cipher key into three round keys
    function automatic t_round_keys expand_key(input logic [15:0] key);
        t_round_keys rk;
        logic [7:0]  w2;
        logic [7:0]  w3;
        logic [7:0]  w4;
        logic [7:0]  w5;
        w2 = key[15:8] ^ RCON1 ^ sub_byte(rot_byte(key[7:0]));
        w3 = w2 ^ key[7:0];
        w4 = w2 ^ RCON2 ^ sub_byte(rot_byte(w3));
        w5 = w4 ^ w3;
        rk.k0 = key;
        rk.k1 = {w2, w3};
        rk.k2 = {w4, w5};
        return rk;
    endfunction

endpackage

`default_nettype wire

>>> sv/simplified_aes_encrypt_unit.sv
// Simplified AES (16-bit) encrypt unit: top level with input and result registers.
// One plaintext block is taken per cycle while o_plain_ready is high. Its ciphertext
// reaches the result port through these registers in order: the request lands in
// the input register, both S-AES rounds run in the logic between that register and
// the result register, and the result register drives the output. A full pipeline
// keeps taking one request per cycle while the consumer takes results; a stalled
// result backs up into the input register, then drops ready. The key is expanded
// into its three round keys when it is written, so a block accepted at or after
// the edge of a key write is encrypted under the new key; write the key only while
// no block is in flight. The key resets to zero.
`default_nettype none

module simplified_aes_encrypt_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // key register write
    input  wire logic        i_cipher_key_we,
    input  wire logic [15:0] i_cipher_key,
    // plaintext request channel
    input  wire logic        i_plain_valid,
    output logic             o_plain_ready,
    input  wire logic [15:0] i_plain_block,
    // ciphertext result channel
    output logic             o_cipher_valid,
    input  wire logic        i_cipher_ready,
    output logic [15:0]      o_cipher_block
);

    saes_pkg::t_round_keys round_keys;

    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [15:0] r_s1_block;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [15:0] r_out_block;
    logic [15:0] cipher_next;
    logic        in_accept;
    logic        s1_advance;

    saes_key_sched u_key_sched (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cipher_key_we (i_cipher_key_we),
        .i_cipher_key    (i_cipher_key),
        .o_round_keys    (round_keys)
    );

    saes_datapath u_datapath (
        .i_block      (r_s1_block),
        .i_round_keys (round_keys),
        .o_block      (cipher_next)
    );

    // Advance the input register when the result register is free or being drained
    assign s1_advance    = r_s1_valid && (!r_out_valid || i_cipher_ready);
    assign o_plain_ready = !r_s1_valid || s1_advance;
    assign in_accept     = i_plain_valid && o_plain_ready;

    // Next valid flags of both stages
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_advance) begin
            n_out_valid = 1'b1;
        end else if (i_cipher_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request and the finished ciphertext
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_block <= i_plain_block;
        end
        if (s1_advance) begin
            r_out_block <= cipher_next;
        end
    end

    assign o_cipher_valid = r_out_valid;
    assign o_cipher_block = r_out_block;

`ifndef SYNTHESIS
    // An accepted request occupies the input register next cycle
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted request did not reach the input register");

    // A request blocked by a stalled result stays put in the input register
    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_cipher_ready)
        |=> (r_s1_valid && $stable(r_s1_block) && !o_plain_ready || r_s1_valid && i_cipher_ready))
        else $error("stalled request was lost or changed");

    // A key write loads the first round key with the written key
    a_key_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cipher_key_we |=> (round_keys.k0 == $past(i_cipher_key)))
        else $error("round key zero does not match the written key");

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_out_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

>>> sv/saes_key_sched.sv
// Key register and registered round keys of the S-AES encrypt unit.
`default_nettype none

module saes_key_sched (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cipher_key_we,
    input  wire logic [15:0]           i_cipher_key,
    output saes_pkg::t_round_keys      o_round_keys
);

    saes_pkg::t_round_keys r_round_keys;

    // Expand the key once at write time; reset holds the expansion of the zero key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_keys <= saes_pkg::expand_key(16'h0000);
        end else if (i_cipher_key_we) begin
            r_round_keys <= saes_pkg::expand_key(i_cipher_key);
        end
    end

    assign o_round_keys = r_round_keys;

endmodule

`default_nettype wire

>>> sv/saes_datapath.sv
// Combinational two-round S-AES encryption of one 16-bit block.
`default_nettype none

module saes_datapath (
    input  wire logic [15:0]           i_block,
    input  wire saes_pkg::t_round_keys i_round_keys,
    output logic [15:0]                o_block
);

    logic [15:0] s_init;
    logic [15:0] s_round1;

    // Add the first round key
    assign s_init = i_block ^ i_round_keys.k0;

    // Round 1: substitute, shift, mix, add key
    assign s_round1 = saes_pkg::mix_block(saes_pkg::shift_block(saes_pkg::sub_block(s_init)))
                    ^ i_round_keys.k1;

    // Round 2: substitute, shift, add key
    assign o_block = saes_pkg::shift_block(saes_pkg::sub_block(s_round1)) ^ i_round_keys.k2;

endmodule

`default_nettype wire
